### rtl/washer_cycle_sequencer_top_assert.svh
// Assertion macros used by the checker file of the washer sequencer.
`ifndef WASHER_CYCLE_SEQUENCER_TOP_ASSERT_SVH
`define WASHER_CYCLE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define WCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("washer sequencer assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define WCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("washer sequencer assertion failed");

`endif

### rtl/wcs_pkg.sv
package wcs_pkg;

    localparam int COUNT_BITS_DEFAULT = 8;

    localparam int CFG_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SOAK_TICKS   = 3'd0,
        REG_WASH_TICKS   = 3'd1,
        REG_DRAIN_TICKS  = 3'd2,
        REG_SPIN_TICKS   = 3'd3,
        REG_RINSE_TICKS  = 3'd4,
        REG_RINSE_ROUNDS = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_FILL   = 4'd1,
        ST_SOAK   = 4'd2,
        ST_WASH   = 4'd3,
        ST_DRAIN  = 4'd4,
        ST_SPIN   = 4'd5,
        ST_REFILL = 4'd6,
        ST_RINSE  = 4'd7,
        ST_DONE   = 4'd8
    } stage_t;

    localparam logic [7:0] PORT_OFF   = 8'h00;
    localparam logic [7:0] PORT_VALVE = 8'h01;
    localparam logic [7:0] PORT_SOAK  = 8'h02;
    localparam logic [7:0] PORT_DRAIN = 8'h04;
    localparam logic [7:0] PORT_DONE  = 8'h20;

    localparam logic [7:0] ROTOR_RESET = 8'h01;

    localparam logic [7:0] SOAK_TICKS_RESET   = 8'd50;
    localparam logic [7:0] WASH_TICKS_RESET   = 8'd50;
    localparam logic [7:0] DRAIN_TICKS_RESET  = 8'd20;
    localparam logic [7:0] SPIN_TICKS_RESET   = 8'd60;
    localparam logic [7:0] RINSE_TICKS_RESET  = 8'd40;
    localparam logic [3:0] RINSE_ROUNDS_RESET = 4'd2;

endpackage

### rtl/washer_cycle_sequencer_top.sv
// Washer cycle sequencer. Each accepted item is one tick with the active-low
// start and tub-full sensor bits; each tick yields exactly one result item with
// the output port byte, the stage after the tick and the short-wait flag. The
// next-state and port logic is a single combinational pass from the state
// registers and the input ports into the result register, so one item is taken
// every cycle and its result appears in the cycle after; a waiting result does not
// block the next tick as long as the result side takes it in the same cycle.
// Timed stages count COUNT_BITS-bit ticks; a count register written as zero
// gives 2^COUNT_BITS ticks. The done stage is held until reset.
module washer_cycle_sequencer_top
    import wcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_start_low,
    input  logic                      s_full_low,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_port_byte,
    output logic [3:0]                m_stage_now,
    output logic                      m_short_wait
);

    typedef logic [COUNT_BITS-1:0] tick_t;

    logic [7:0] soak_ticks_reg, wash_ticks_reg, drain_ticks_reg;
    logic [7:0] spin_ticks_reg, rinse_ticks_reg;
    logic [3:0] rinse_rounds_reg;

    stage_t     stage_reg, stage_next;
    tick_t      tick_reg, tick_next, tick_dec;
    logic [7:0] rotor_reg, rotor_next, rotor_shift;
    logic       blink_reg, blink_next;
    logic [3:0] rounds_reg, rounds_next;
    logic [7:0] port_raw, port_next;
    logic       count_done;

    logic       m_valid_reg;
    logic [7:0] port_reg;
    stage_t     stage_out_reg;
    logic       short_reg;

    logic       accept;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_port_byte  = port_reg;
    assign m_stage_now  = stage_out_reg;
    assign m_short_wait = short_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soak_ticks_reg   <= SOAK_TICKS_RESET;
            wash_ticks_reg   <= WASH_TICKS_RESET;
            drain_ticks_reg  <= DRAIN_TICKS_RESET;
            spin_ticks_reg   <= SPIN_TICKS_RESET;
            rinse_ticks_reg  <= RINSE_TICKS_RESET;
            rinse_rounds_reg <= RINSE_ROUNDS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOAK_TICKS:   soak_ticks_reg   <= cfg_wdata;
                REG_WASH_TICKS:   wash_ticks_reg   <= cfg_wdata;
                REG_DRAIN_TICKS:  drain_ticks_reg  <= cfg_wdata;
                REG_SPIN_TICKS:   spin_ticks_reg   <= cfg_wdata;
                REG_RINSE_TICKS:  rinse_ticks_reg  <= cfg_wdata;
                REG_RINSE_ROUNDS: rinse_rounds_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Decrement first; the exit tick is the one that reaches zero.
    assign tick_dec    = tick_reg - tick_t'(1);
    assign count_done  = (tick_dec == '0);
    assign rotor_shift = {rotor_reg[6:0], 1'b0};

    always_comb begin
        stage_next  = stage_reg;
        tick_next   = tick_reg;
        rotor_next  = rotor_reg;
        rounds_next = rounds_reg;
        port_raw    = PORT_OFF;
        case (stage_reg)
            ST_IDLE: begin
                if (!s_start_low) begin
                    stage_next  = ST_FILL;
                    port_raw    = PORT_VALVE;
                    rounds_next = rinse_rounds_reg;
                end
            end
            ST_FILL: begin
                if (!s_full_low) begin
                    stage_next = ST_SOAK;
                    port_raw   = PORT_SOAK;
                    tick_next  = COUNT_BITS'(soak_ticks_reg);
                end else begin
                    port_raw = PORT_VALVE;
                end
            end
            ST_SOAK: begin
                tick_next = tick_dec;
                if (count_done) begin
                    stage_next = ST_WASH;
                    tick_next  = COUNT_BITS'(wash_ticks_reg);
                end else begin
                    port_raw = PORT_SOAK;
                end
            end
            ST_WASH: begin
                tick_next = tick_dec;
                if (count_done) begin
                    stage_next = ST_DRAIN;
                    port_raw   = PORT_DRAIN;
                    tick_next  = COUNT_BITS'(drain_ticks_reg);
                end else begin
                    rotor_next = (rotor_shift == '0) ? ROTOR_RESET : rotor_shift;
                    port_raw   = rotor_next;
                end
            end
            ST_DRAIN: begin
                tick_next = tick_dec;
                if (count_done) begin
                    stage_next = ST_SPIN;
                    tick_next  = COUNT_BITS'(spin_ticks_reg);
                end else begin
                    port_raw = PORT_DRAIN;
                end
            end
            ST_SPIN: begin
                tick_next = tick_dec;
                if (count_done) begin
                    if (rounds_reg != '0) begin
                        rounds_next = rounds_reg - 4'd1;
                        stage_next  = ST_REFILL;
                    end else begin
                        stage_next = ST_DONE;
                    end
                end else begin
                    rotor_next = (rotor_shift == '0) ? ROTOR_RESET : rotor_shift;
                    port_raw   = rotor_next;
                end
            end
            ST_REFILL: begin
                if (!s_full_low) begin
                    stage_next = ST_RINSE;
                    rotor_next = (rotor_shift == '0) ? ROTOR_RESET : rotor_shift;
                    port_raw   = rotor_next;
                    tick_next  = COUNT_BITS'(rinse_ticks_reg);
                end else begin
                    port_raw = PORT_VALVE;
                end
            end
            ST_RINSE: begin
                tick_next = tick_dec;
                if (count_done) begin
                    stage_next = ST_DRAIN;
                    tick_next  = COUNT_BITS'(drain_ticks_reg);
                end else begin
                    rotor_next = (rotor_shift == '0) ? ROTOR_RESET : rotor_shift;
                    port_raw   = rotor_next;
                end
            end
            ST_DONE: begin
                port_raw = PORT_DONE;
            end
            default: ;
        endcase

        // Blink on even stages and fill: dark on every other such tick.
        blink_next = blink_reg;
        port_next  = port_raw;
        if (!stage_next[0] || stage_next == ST_FILL) begin
            blink_next = !blink_reg;
            if (!blink_next) begin
                port_next = PORT_OFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= ST_IDLE;
            tick_reg    <= '0;
            rotor_reg   <= ROTOR_RESET;
            blink_reg   <= 1'b0;
            rounds_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                stage_reg   <= stage_next;
                tick_reg    <= tick_next;
                rotor_reg   <= rotor_next;
                blink_reg   <= blink_next;
                rounds_reg  <= rounds_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            port_reg      <= port_next;
            stage_out_reg <= stage_next;
            short_reg     <= (stage_next == ST_SPIN);
        end
    end

endmodule

### rtl/wcs_checker.sv
`include "washer_cycle_sequencer_top_assert.svh"

module wcs_checker
    import wcs_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_port_byte,
    input logic [3:0] m_stage_now,
    input logic       m_short_wait
);

    // Hold a stalled result item.
    `WCS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_port_byte) && $stable(m_stage_now) && $stable(m_short_wait))

    `WCS_ASSERT_IMPL(a_short_wait_spin, m_valid, m_short_wait == (m_stage_now == ST_SPIN))

    // Port byte is one fixed bit, one rotor bit, or dark.
    `WCS_ASSERT_IMPL(a_port_onehot0, m_valid, $onehot0(m_port_byte))

    `WCS_ASSERT_IMPL(a_done_port, m_valid && m_stage_now == ST_DONE, m_port_byte == PORT_DONE || m_port_byte == PORT_OFF)

endmodule

bind washer_cycle_sequencer_top wcs_checker u_wcs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_port_byte  (m_port_byte),
    .m_stage_now  (m_stage_now),
    .m_short_wait (m_short_wait)
);

### dv/washer_cycle_sequencer_top_test.sv
`timescale 1ns / 100ps

module washer_cycle_sequencer_top_test;
    import wcs_pkg::*;

    localparam int N_PHASES       = 8;
    localparam int PHASE_TICKS    = 219;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_ROWS         = 20;

    // Indexes past the register map; the block must ignore writes to them.
    localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [7:0] port;
        logic [3:0] stage;
        logic       short_wait;
    } tick_res_t;

    typedef struct packed {
        logic      start_low;
        logic      full_low;
        bit        typed;
        tick_res_t res;
    } tick_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_start_low = 1'b1;
    logic                      s_full_low = 1'b1;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [7:0]                m_port_byte;
    logic [3:0]                m_stage_now;
    logic                      m_short_wait;

    washer_cycle_sequencer_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_low  (s_start_low),
        .s_full_low   (s_full_low),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_port_byte  (m_port_byte),
        .m_stage_now  (m_stage_now),
        .m_short_wait (m_short_wait)
    );

    always #5 aclk = ~aclk;

    // Register copies
    logic [7:0] cfg_soak   = SOAK_TICKS_RESET;
    logic [7:0] cfg_wash   = WASH_TICKS_RESET;
    logic [7:0] cfg_drain  = DRAIN_TICKS_RESET;
    logic [7:0] cfg_spin   = SPIN_TICKS_RESET;
    logic [7:0] cfg_rinse  = RINSE_TICKS_RESET;
    logic [3:0] cfg_rounds = RINSE_ROUNDS_RESET;

    // Sequencer state as predicted
    stage_t                        pr_stage = ST_IDLE;
    logic [COUNT_BITS_DEFAULT-1:0] pr_ticks = '0;
    logic [7:0]                    pr_rotor = ROTOR_RESET;
    logic                          pr_blink = 1'b0;
    logic [3:0]                    pr_rounds = '0;

    tick_res_t expected_ticks[$];
    pace_t     pace = PACE_FULL;
    int        mismatches = 0;
    int        ticks_sent = 0;
    int        results_seen = 0;
    int        done_results = 0;
    int        quiet_cycles = 0;
    logic [15:0] stages_reached = '0;

    // Directed walk with short counts: idle, start, fill, soak, wash, drain,
    // spin and two refill/rinse rounds, start held low where it is ignored.
    tick_row_t tick_rows [0:N_ROWS-1] = '{
        '{1'b1, 1'b1, 1'b1, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b0, 1'b1, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b1, 1'b1, '{PORT_VALVE, ST_FILL, 1'b0}},
        '{1'b0, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b0, 1'b0, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '{PORT_OFF,   ST_IDLE, 1'b0}}
    };

    function automatic logic count_expired();
        pr_ticks = pr_ticks - 1'b1;
        return pr_ticks == '0;
    endfunction

    function automatic logic [7:0] rotor_advance();
        pr_rotor = {pr_rotor[6:0], 1'b0};
        if (pr_rotor == 8'h00) begin
            pr_rotor = ROTOR_RESET;
        end
        return pr_rotor;
    endfunction

    function automatic tick_res_t wash_tick_predict(input logic start_low,
                                                    input logic full_low);
        tick_res_t  r;
        logic [7:0] port;
        port = PORT_OFF;
        case (pr_stage)
            ST_IDLE: begin
                if (!start_low) begin
                    pr_stage  = ST_FILL;
                    port      = PORT_VALVE;
                    pr_rounds = cfg_rounds;
                end
            end
            ST_FILL: begin
                if (!full_low) begin
                    pr_stage = ST_SOAK;
                    port     = PORT_SOAK;
                    pr_ticks = cfg_soak;
                end else begin
                    port = PORT_VALVE;
                end
            end
            ST_SOAK: begin
                if (count_expired()) begin
                    pr_stage = ST_WASH;
                    pr_ticks = cfg_wash;
                end else begin
                    port = PORT_SOAK;
                end
            end
            ST_WASH: begin
                if (count_expired()) begin
                    pr_stage = ST_DRAIN;
                    port     = PORT_DRAIN;
                    pr_ticks = cfg_drain;
                end else begin
                    port = rotor_advance();
                end
            end
            ST_DRAIN: begin
                if (count_expired()) begin
                    pr_stage = ST_SPIN;
                    pr_ticks = cfg_spin;
                end else begin
                    port = PORT_DRAIN;
                end
            end
            ST_SPIN: begin
                if (count_expired()) begin
                    if (pr_rounds != '0) begin
                        pr_rounds = pr_rounds - 1'b1;
                        pr_stage  = ST_REFILL;
                    end else begin
                        pr_stage = ST_DONE;
                    end
                end else begin
                    port = rotor_advance();
                end
            end
            ST_REFILL: begin
                if (!full_low) begin
                    pr_stage = ST_RINSE;
                    port     = rotor_advance();
                    pr_ticks = cfg_rinse;
                end else begin
                    port = PORT_VALVE;
                end
            end
            ST_RINSE: begin
                if (count_expired()) begin
                    pr_stage = ST_DRAIN;
                    pr_ticks = cfg_drain;
                end else begin
                    port = rotor_advance();
                end
            end
            ST_DONE: begin
                port = PORT_DONE;
            end
            default: begin
                port = PORT_OFF;
            end
        endcase
        // Blink even stages and fill: show the byte on alternate ticks only
        if (pr_stage[0] == 1'b0 || pr_stage == ST_FILL) begin
            pr_blink = ~pr_blink;
            if (!pr_blink) begin
                port = PORT_OFF;
            end
        end
        r.port       = port;
        r.stage      = pr_stage;
        r.short_wait = (pr_stage == ST_SPIN);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SOAK_TICKS:   cfg_soak = val;
            REG_WASH_TICKS:   cfg_wash = val;
            REG_DRAIN_TICKS:  cfg_drain = val;
            REG_SPIN_TICKS:   cfg_spin = val;
            REG_RINSE_TICKS:  cfg_rinse = val;
            REG_RINSE_ROUNDS: cfg_rounds = val[3:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic start_low, input logic full_low,
                             input bit typed, input tick_res_t typed_res);
        int        gap_pct;
        tick_res_t want;
        gap_pct = (pace == PACE_SEND_GAPS) ? 81 : (pace == PACE_BOTH) ? 19 : 0;
        @(negedge aclk);
        while ($urandom_range(99, 0) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_low <= start_low;
        s_full_low  <= full_low;
        // Hold the item until it is taken
        do begin
            @(posedge aclk);
        end while (!s_ready);
        want = wash_tick_predict(start_low, full_low);
        expected_ticks.push_back(typed ? typed_res : want);
        ticks_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= !($urandom_range(99, 0) <
            ((pace == PACE_SINK_STALLS) ? 81 : (pace == PACE_BOTH) ? 19 : 0));
    end

    always @(posedge aclk) begin : result_check
        tick_res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            stages_reached[m_stage_now] <= 1'b1;
            if (m_stage_now == ST_DONE) begin
                done_results++;
            end
            if (expected_ticks.size() == 0) begin
                $display("%0t: result with nothing expected: port %02h stage %0d short %0b",
                         $time, m_port_byte, m_stage_now, m_short_wait);
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                if (m_port_byte !== want.port) begin
                    $display("%0t: port_byte expected %02h, got %02h",
                             $time, want.port, m_port_byte);
                    mismatches++;
                end
                if (m_stage_now !== want.stage) begin
                    $display("%0t: stage_now expected %0d, got %0d",
                             $time, want.stage, m_stage_now);
                    mismatches++;
                end
                if (m_short_wait !== want.short_wait) begin
                    $display("%0t: short_wait expected %0b, got %0b",
                             $time, want.short_wait, m_short_wait);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, expected_ticks.size());
                $display("** washer_cycle_sequencer_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cfg_index_t idx;
        int         cnt_lo;
        int         cnt_hi;
        int         full_pct;
        tick_res_t  no_res;
        no_res = '0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Short counts for the walk; upper round bits must be masked off
        write_reg(REG_SOAK_TICKS, 8'd1);
        write_reg(REG_WASH_TICKS, 8'd2);
        write_reg(REG_DRAIN_TICKS, 8'd1);
        write_reg(REG_SPIN_TICKS, 8'd1);
        write_reg(REG_RINSE_TICKS, 8'd1);
        write_reg(REG_RINSE_ROUNDS, 8'hFF);
        write_reg(IDX_SPARE_LO, 8'h00);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;

        for (int i = 0; i < N_ROWS; i++) begin
            send_tick(tick_rows[i].start_low, tick_rows[i].full_low,
                      tick_rows[i].typed, tick_rows[i].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin cnt_lo = 4;   cnt_hi = 30;  end
                1: begin cnt_lo = 0;   cnt_hi = 0;   end
                2: begin cnt_lo = 255; cnt_hi = 255; end
                3: begin cnt_lo = 1;   cnt_hi = 40;  end
                4: begin cnt_lo = 1;   cnt_hi = 20;  end
                5: begin cnt_lo = 1;   cnt_hi = 10;  end
                6: begin cnt_lo = 1;   cnt_hi = 4;   end
                default: begin cnt_lo = 1; cnt_hi = 1; end
            endcase
            for (idx = REG_SOAK_TICKS; idx <= REG_RINSE_TICKS; idx = cfg_index_t'(idx + 1)) begin
                write_reg(idx, 8'($urandom_range(cnt_hi, cnt_lo)));
            end
            write_reg(REG_RINSE_ROUNDS, (ph == 2) ? 8'h0F : (ph == 7) ? 8'h00 :
                                         8'($urandom_range(255, 0)));
            write_reg((ph % 2 == 0) ? IDX_SPARE_LO : IDX_SPARE_HI, 8'($urandom_range(255, 0)));
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            pace     = pace_t'(ph % 4);
            full_pct = $urandom_range(80, 20);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                // Let the block run dry once in the middle of a phase
                if (ph == 1 && i == PHASE_TICKS / 2) begin
                    drain_results();
                end
                send_tick(1'($urandom_range(1, 0)), !($urandom_range(99, 0) < full_pct),
                          1'b0, no_res);
            end
        end

        drain_results();
        $display("Run: %0d ticks in, %0d results checked, %0d of them in the done stage.",
                 ticks_sent, results_seen, done_results);
        $display("Stages seen (bit per stage) %b; counts from 1 to 255 and the zero wrap.",
                 stages_reached[8:0]);
        if (mismatches == 0) begin
            $display("** washer_cycle_sequencer_top: PASSED **");
        end else begin
            $display("** washer_cycle_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/wcs_pkg.sv
rtl/washer_cycle_sequencer_top.sv
rtl/wcs_checker.sv
dv/washer_cycle_sequencer_top_test.sv
